// File: rtl/core/fbrle_pkg.sv
`timescale 1ns / 1ps

package fbrle_pkg;

  // Default width of the running decoded-byte total.
  localparam int TOTAL_BITS_DEF = 24;

  // Field widths of the result channel.
  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 8;
  localparam int LEN_W    = 17;
  localparam int OFFS_W   = 26;
  localparam int COUNT_W  = 24;
  localparam int STRIDE_W = 3;

  // Descriptor kinds.
  localparam logic [KIND_W-1:0] KIND_LIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic go;         // perform one resolve step this cycle
    logic sel_input;  // step consumes in_byte (otherwise an implied zero)
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic cont;       // an implied-zero field follows the current step
  } status_t;

endpackage

// File: rtl/core/fbrle_ctrl.sv
`timescale 1ns / 1ps

module fbrle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fbrle_pkg::status_t status,
  output fbrle_pkg::cmd_t    cmd,
  output logic              busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOP = 1'b1;

  logic st_r;
  logic st_nxt;

  always_comb begin
    cmd.sel_input = 1'b0;
    cmd.go        = 1'b0;
    st_nxt        = st_r;
    unique case (st_r)
      ST_IDLE: begin
        cmd.sel_input = 1'b1;
        cmd.go        = in_valid && status.out_free;
      end
      ST_LOOP: begin
        cmd.go = status.out_free;
      end
      default: begin
        cmd.go = 1'b0;
      end
    endcase
    if (cmd.go) begin
      st_nxt = status.cont ? ST_LOOP : ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_stall = (st_r != ST_IDLE) || !status.out_free;
  assign busy     = (st_r == ST_LOOP);

endmodule

// File: rtl/core/fbrle_dp.sv
`timescale 1ns / 1ps

module fbrle_dp #(
  parameter int TOTAL_BITS = fbrle_pkg::TOTAL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbrle_pkg::cmd_t                      cmd,
  output fbrle_pkg::status_t                   status,
  input  logic [7:0]                          in_byte,
  input  logic                                cfg_we,
  input  logic [fbrle_pkg::STRIDE_W-1:0]      cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [fbrle_pkg::KIND_W-1:0]        out_kind,
  output logic [fbrle_pkg::VALUE_W-1:0]       out_run_value,
  output logic [fbrle_pkg::LEN_W-1:0]         out_run_length,
  output logic [fbrle_pkg::OFFS_W-1:0]        out_start_offset,
  output logic [fbrle_pkg::COUNT_W-1:0]       out_total_count,
  output logic                                out_last_of_item
);

  localparam int LW = fbrle_pkg::LEN_W;
  localparam int SW = ((TOTAL_BITS > LW) ? TOTAL_BITS : LW) + 1;
  localparam int PW = ((TOTAL_BITS + 3) > fbrle_pkg::OFFS_W) ?
                      (TOTAL_BITS + 3) : fbrle_pkg::OFFS_W;
  localparam int CW = (TOTAL_BITS > fbrle_pkg::COUNT_W) ? TOTAL_BITS : fbrle_pkg::COUNT_W;
  localparam logic [TOTAL_BITS-1:0] TOTAL_CAP = {TOTAL_BITS{1'b1}};

  localparam logic [1:0] PH_SYM = 2'd0;
  localparam logic [1:0] PH_CNT = 2'd1;
  localparam logic [1:0] PH_HI  = 2'd2;
  localparam logic [1:0] PH_LO  = 2'd3;

  localparam logic [8:0] PREV_NONE = 9'h100;

  logic [fbrle_pkg::STRIDE_W-1:0] stride_r;
  logic [fbrle_pkg::STRIDE_W-1:0] stride_eff;

  logic [7:0]            flag_r,  flag_nxt;
  logic [7:0]            mask_r,  mask_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [8:0]            prev_r,  prev_nxt;
  logic [LW-1:0]         acc_r,   acc_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;

  logic [7:0]                     v;
  logic                           emit;
  logic                           is_end;
  logic                           cont;
  logic [fbrle_pkg::KIND_W-1:0]   e_kind;
  logic [7:0]                     e_val;
  logic [LW-1:0]                  e_len;
  logic [SW-1:0]                  sum;
  logic [PW-1:0]                  prod;
  logic [CW-1:0]                  count_ext;

  logic                           out_valid_r;
  logic [fbrle_pkg::KIND_W-1:0]   kind_r;
  logic [7:0]                     val_r;
  logic [LW-1:0]                  len_r;
  logic [fbrle_pkg::OFFS_W-1:0]   offs_r;
  logic [fbrle_pkg::COUNT_W-1:0]  count_r;
  logic                           last_r;
  logic                           out_free;

  // Stride codes outside 1..4 clamp to the nearest legal stride.
  always_comb begin
    unique case (stride_r) inside
      3'd0:                    stride_eff = 3'd1;
      3'd1, 3'd2, 3'd3, 3'd4:  stride_eff = stride_r;
      default:                 stride_eff = 3'd4;
    endcase
  end

  assign prod = PW'(total_r) * PW'(stride_eff);

  always_comb begin
    flag_nxt  = flag_r;
    mask_nxt  = mask_r;
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    acc_nxt   = acc_r;
    total_nxt = total_r;
    emit      = 1'b0;
    is_end    = 1'b0;
    cont      = 1'b0;
    e_kind    = fbrle_pkg::KIND_LIT;
    e_val     = 8'd0;
    e_len     = '0;
    sum       = '0;
    v         = cmd.sel_input ? in_byte : 8'd0;

    if (cmd.sel_input && (mask_r == 8'd0)) begin
      flag_nxt = in_byte;
      mask_nxt = 8'h80;
      cont     = !in_byte[7];
    end else begin
      unique case (phase_r)
        PH_SYM: begin
          if (cmd.sel_input && (v == 8'd0)) begin
            is_end = 1'b1;
            emit   = 1'b1;
            e_kind = fbrle_pkg::KIND_END;
          end else begin
            emit   = 1'b1;
            e_kind = fbrle_pkg::KIND_LIT;
            e_val  = v;
            e_len  = LW'(1);
            if (prev_r == {1'b0, v}) begin
              phase_nxt = PH_CNT;
            end else begin
              prev_nxt = {1'b0, v};
            end
          end
        end
        PH_CNT: begin
          if (v < 8'd254) begin
            emit      = 1'b1;
            e_kind    = fbrle_pkg::KIND_RUN;
            e_val     = prev_r[7:0];
            e_len     = LW'(v);
            prev_nxt  = PREV_NONE;
            acc_nxt   = '0;
            phase_nxt = PH_SYM;
          end else if (v == 8'd254) begin
            acc_nxt   = LW'(254);
            phase_nxt = PH_LO;
          end else begin
            acc_nxt   = LW'(510);
            phase_nxt = PH_HI;
          end
        end
        PH_HI: begin
          acc_nxt   = acc_r + {1'b0, v, 8'd0};
          phase_nxt = PH_LO;
        end
        PH_LO: begin
          emit      = 1'b1;
          e_kind    = fbrle_pkg::KIND_RUN;
          e_val     = prev_r[7:0];
          e_len     = acc_r + LW'(v);
          prev_nxt  = PREV_NONE;
          acc_nxt   = '0;
          phase_nxt = PH_SYM;
        end
      endcase

      if (is_end) begin
        flag_nxt  = 8'd0;
        mask_nxt  = 8'd0;
        phase_nxt = PH_SYM;
        prev_nxt  = PREV_NONE;
        acc_nxt   = '0;
        total_nxt = '0;
      end else begin
        mask_nxt = mask_r >> 1;
        cont     = |((mask_r >> 1) & ~flag_r);
        if (emit) begin
          sum = SW'(total_r) + SW'(e_len);
          total_nxt = (sum > SW'(TOTAL_CAP)) ? TOTAL_CAP : sum[TOTAL_BITS-1:0];
        end
      end
    end
  end

  // The end descriptor reports the length before the clear.
  assign count_ext = is_end ? CW'(total_r) : CW'(total_nxt);

  assign out_free = !out_valid_r || !out_stall;
  assign status.out_free = out_free;
  assign status.cont     = cont;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= fbrle_pkg::STRIDE_W'(1);
      flag_r   <= 8'd0;
      mask_r   <= 8'd0;
      phase_r  <= PH_SYM;
      prev_r   <= PREV_NONE;
      acc_r    <= '0;
      total_r  <= '0;
    end else begin
      if (cfg_we) begin
        stride_r <= cfg_data;
      end
      if (cmd.go) begin
        flag_r  <= flag_nxt;
        mask_r  <= mask_nxt;
        phase_r <= phase_nxt;
        prev_r  <= prev_nxt;
        acc_r   <= acc_nxt;
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go && emit) begin
      kind_r  <= e_kind;
      val_r   <= e_val;
      len_r   <= e_len;
      offs_r  <= prod[fbrle_pkg::OFFS_W-1:0];
      count_r <= count_ext[fbrle_pkg::COUNT_W-1:0];
      last_r  <= is_end || !cont;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_run_value    = val_r;
  assign out_run_length   = len_r;
  assign out_start_offset = offs_r;
  assign out_total_count  = count_r;
  assign out_last_of_item = last_r;

endmodule

// File: rtl/core/flag_bit_rle_byte_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_byte
// out      output     out_valid / out_stall kind, run_value, run_length, start_offset,
//                                          total_count, last_of_item
// cfg      input      cfg_valid / cfg_ready cfg_output_stride
//
// Each beat on the input is followed by one resolve step for every implied-zero
// field that its flag byte resolves right after it; no new byte is taken meanwhile.
// The flag-bit walk in the controller does this, one field per cycle when not stalled.
// A result waiting in the output register under out_stall holds the walk.
// Reset (rst_n low, synchronous) clears the stream state and sets the stride to 1.

module flag_bit_rle_byte_decoder #(
  parameter int TOTAL_BITS = fbrle_pkg::TOTAL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fbrle_pkg::KIND_W-1:0]        out_kind,
  output logic [fbrle_pkg::VALUE_W-1:0]       out_run_value,
  output logic [fbrle_pkg::LEN_W-1:0]         out_run_length,
  output logic [fbrle_pkg::OFFS_W-1:0]        out_start_offset,
  output logic [fbrle_pkg::COUNT_W-1:0]       out_total_count,
  output logic                                out_last_of_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbrle_pkg::STRIDE_W-1:0]      cfg_output_stride
);

  fbrle_pkg::cmd_t    cmd;
  fbrle_pkg::status_t status;
  logic               busy;

  assign cfg_ready = 1'b1;

  fbrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  fbrle_dp #(
    .TOTAL_BITS (TOTAL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_byte          (in_byte),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_output_stride),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_run_value    (out_run_value),
    .out_run_length   (out_run_length),
    .out_start_offset (out_start_offset),
    .out_total_count  (out_total_count),
    .out_last_of_item (out_last_of_item)
  );

  // No new byte is taken while implied-zero fields are still being walked.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input accepted during flag walk");

  // The walk only starts right after an accepted byte.
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(in_valid && !in_stall))
    else $error("flag walk started without an input beat");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == fbrle_pkg::KIND_END)) |->
      (out_last_of_item && (out_run_length == '0)))
    else $error("end descriptor malformed");

  a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == fbrle_pkg::KIND_LIT)) |-> (out_run_length == 17'd1))
    else $error("literal with length other than one");

endmodule
